### rtl/otb_pkg.sv
// shared types and constants for the one-shot timer bank
`timescale 1ns / 1ps

package otb_pkg;

   localparam int SLOTS  = 8;
   localparam int SLOT_W = 3;
   localparam int OP_W   = 3;
   localparam int TAG_W  = 8;
   localparam int TICK_W = 32;
   localparam int DUR_W  = 32;
   localparam int TPM_W  = 16;

   localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 3'd0,
      OP_START   = 3'd1,
      OP_STOP    = 3'd2,
      OP_REBASE  = 3'd3,
      OP_RELEASE = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic start_wr;
      logic scan_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic mask_empty;
      logic out_free;
   } status_type;

endpackage

### rtl/otb_ifs.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface otb_req_if;
   import otb_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [SLOT_W-1:0] slot;
   logic [TAG_W-1:0]  tag;
   logic [DUR_W-1:0]  duration_ms;
   logic [TICK_W-1:0] tick_value;

   modport source (output valid, operation, slot, tag, duration_ms, tick_value,
                   input ready);
   modport sink (input valid, operation, slot, tag, duration_ms, tick_value,
                 output ready);
endinterface

interface otb_rsp_if;
   import otb_pkg::*;

   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] expired_slot;
   logic [TAG_W-1:0]  expired_tag;
   logic              last;

   modport source (output valid, expired_slot, expired_tag, last, input ready);
   modport sink (input valid, expired_slot, expired_tag, last, output ready);
endinterface

### rtl/one_shot_timer_bank.sv
// Stop, release and rebase take effect on acceptance; start is captured on acceptance and written
// in the START state, which does the scaling multiply. A tick is accepted, then scanned in the SCAN
// state (one slot compare per cycle); EMIT then registers one response word per expired slot,
// holding while the previous word is not taken. The bank handles one request at a time.
// Reset clears all armed flags, the current tick and the rsp_valid flag; ticks_per_ms goes to 1.
`timescale 1ns / 1ps

module one_shot_timer_bank (
   input  logic                      clock,
   input  logic                      reset,
   otb_req_if.sink                   req_chan,
   otb_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [otb_pkg::TPM_W-1:0]  csr_wdata
);
   import otb_pkg::*;

   cmd_type    cmd;
   status_type status;

   otb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .status        (status),
      .cmd           (cmd)
   );

   otb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_operation    (req_chan.operation),
      .req_slot         (req_chan.slot),
      .req_tag          (req_chan.tag),
      .req_duration_ms  (req_chan.duration_ms),
      .req_tick_value   (req_chan.tick_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_expired_slot (rsp_chan.expired_slot),
      .rsp_expired_tag  (rsp_chan.expired_tag),
      .rsp_last         (rsp_chan.last)
   );

endmodule

### rtl/otb_ctrl.sv
// controller state machine for the timer bank
`timescale 1ns / 1ps

module otb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [otb_pkg::OP_W-1:0] req_operation,
   output logic                    req_ready,
   input  otb_pkg::status_type     status,
   output otb_pkg::cmd_type        cmd
);
   import otb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation)
                  OP_TICK:  state_in = ST_SCAN;
                  OP_START: state_in = ST_START;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_START: state_in = ST_IDLE;
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.mask_empty) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.start_wr  = (state_ff == ST_START);
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.emit      = (state_ff == ST_EMIT) && !status.mask_empty && status.out_free;
   end

   a_scan_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && status.scan_last |=> (state_ff == ST_EMIT))
      else $error("scan did not hand over to emit");

endmodule

### rtl/otb_dp.sv
// slot storage, scaling multiplier, expiry scan and response register
`timescale 1ns / 1ps

module otb_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [otb_pkg::TPM_W-1:0]  csr_wdata,
   input  logic [otb_pkg::OP_W-1:0]   req_operation,
   input  logic [otb_pkg::SLOT_W-1:0] req_slot,
   input  logic [otb_pkg::TAG_W-1:0]  req_tag,
   input  logic [otb_pkg::DUR_W-1:0]  req_duration_ms,
   input  logic [otb_pkg::TICK_W-1:0] req_tick_value,
   input  otb_pkg::cmd_type           cmd,
   output otb_pkg::status_type        status,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [otb_pkg::SLOT_W-1:0] rsp_expired_slot,
   output logic [otb_pkg::TAG_W-1:0]  rsp_expired_tag,
   output logic                      rsp_last
);
   import otb_pkg::*;

   logic [SLOTS-1:0]              armed_ff, armed_in;
   logic [SLOTS-1:0][TICK_W-1:0]  start_ff, start_in;
   logic [SLOTS-1:0][TICK_W-1:0]  limit_ff, limit_in;
   logic [SLOTS-1:0][TAG_W-1:0]   tag_ff, tag_in;
   logic [TICK_W-1:0]             now_ff, now_in;
   logic [TPM_W-1:0]              tpm_ff, tpm_in;
   logic [SLOT_W-1:0]             slot_ff, slot_in;
   logic [TAG_W-1:0]              itag_ff, itag_in;
   logic [DUR_W-1:0]              dur_ff, dur_in;
   logic [SLOT_W-1:0]             idx_ff, idx_in;
   logic [SLOTS-1:0]              expire_ff, expire_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]             rsp_slot_ff, rsp_slot_in;
   logic [TAG_W-1:0]              rsp_tag_ff, rsp_tag_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [TICK_W-1:0]       elapsed;
   logic                    hit;
   logic [DUR_W+TPM_W-1:0]  product;
   logic [SLOT_W-1:0]       pick;
   logic [SLOTS-1:0]        rest;
   logic                    req_slot_ok;
   logic                    hold_slot_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= '0;
         now_ff       <= '0;
         tpm_ff       <= TPM_RESET;
         idx_ff       <= '0;
         expire_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         armed_ff     <= armed_in;
         now_ff       <= now_in;
         tpm_ff       <= tpm_in;
         idx_ff       <= idx_in;
         expire_ff    <= expire_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      limit_ff    <= limit_in;
      tag_ff      <= tag_in;
      slot_ff     <= slot_in;
      itag_ff     <= itag_in;
      dur_ff      <= dur_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      elapsed      = now_ff - start_ff[idx_ff];
      hit          = armed_ff[idx_ff] && (elapsed >= limit_ff[idx_ff]);
      product      = dur_ff * tpm_ff;
      req_slot_ok  = ({1'b0, req_slot} < (SLOT_W+1)'(SLOTS));
      hold_slot_ok = ({1'b0, slot_ff} < (SLOT_W+1)'(SLOTS));

      pick = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (expire_ff[i]) pick = SLOT_W'(i);
      end
      rest       = expire_ff;
      rest[pick] = 1'b0;

      armed_in     = armed_ff;
      start_in     = start_ff;
      limit_in     = limit_ff;
      tag_in       = tag_ff;
      now_in       = now_ff;
      tpm_in       = tpm_ff;
      slot_in      = slot_ff;
      itag_in      = itag_ff;
      dur_in       = dur_ff;
      idx_in       = idx_ff;
      expire_in    = expire_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_we) tpm_in = csr_wdata;

      if (cmd.load) begin
         slot_in = req_slot;
         itag_in = req_tag;
         dur_in  = req_duration_ms;
         idx_in  = '0;
         case (req_operation)
            OP_TICK: now_in = req_tick_value;
            OP_REBASE: begin
               now_in = req_tick_value;
               for (int i = 0; i < SLOTS; i++) begin
                  if (armed_ff[i]) start_in[i] = req_tick_value;
               end
            end
            OP_STOP: begin
               if (req_slot_ok) armed_in[req_slot] = 1'b0;
            end
            OP_RELEASE: begin
               if (req_slot_ok) begin
                  armed_in[req_slot] = 1'b0;
                  start_in[req_slot] = '0;
                  limit_in[req_slot] = '0;
                  tag_in[req_slot]   = '0;
               end
            end
            default: ;
         endcase
      end

      if (cmd.start_wr && hold_slot_ok && (dur_ff != '0)) begin
         limit_in[slot_ff] = product[TICK_W-1:0];
         start_in[slot_ff] = now_ff;
         tag_in[slot_ff]   = itag_ff;
         armed_in[slot_ff] = 1'b1;
      end

      if (cmd.scan_step) begin
         expire_in[idx_ff] = hit;
         if (hit) armed_in[idx_ff] = 1'b0;
         idx_in = idx_ff + 1'b1;
      end

      if (cmd.emit) begin
         expire_in[pick] = 1'b0;
         rsp_valid_in    = 1'b1;
         rsp_slot_in     = pick;
         rsp_tag_in      = tag_ff[pick];
         rsp_last_in     = (rest == '0);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      status.scan_last  = (idx_ff == SLOT_W'(SLOTS - 1));
      status.mask_empty = (expire_ff == '0);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_expired_slot = rsp_slot_ff;
   assign rsp_expired_tag  = rsp_tag_ff;
   assign rsp_last         = rsp_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response word overwritten before taken");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !expire_ff[$past(pick)])
      else $error("reported slot still pending");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && (rest == '0) |=> (expire_ff == '0) && rsp_last_ff)
      else $error("last word sent with expiries pending");

endmodule

### verif/one_shot_timer_bank_tb.sv
// self-checking testbench for the one-shot timer bank
`timescale 1ns / 1ps

module one_shot_timer_bank_tb;
   import otb_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 2 * SLOTS + 10;
   localparam int PRESSURE_HOLD = 300;
   localparam int REPORT_MAX    = 10;

   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   localparam logic [TPM_W-1:0] TPM_MAX  = 16'hFFFF;
   localparam logic [TPM_W-1:0] TPM_HALF = 16'h8000;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [TAG_W-1:0]  tag;
      logic              last;
   } expiry_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [TPM_W-1:0] csr_wdata;

   otb_req_if req_if ();
   otb_rsp_if rsp_if ();

   one_shot_timer_bank dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // timer bank state as the testbench predicts it
   logic              timer_armed [SLOTS];
   logic [TICK_W-1:0] timer_start [SLOTS];
   logic [TICK_W-1:0] timer_limit [SLOTS];
   logic [TAG_W-1:0]  timer_tag   [SLOTS];
   logic [TICK_W-1:0] bank_now;
   logic [TPM_W-1:0]  bank_tpm;

   expiry_word_type expiry_q [$];

   int mismatches = 0;
   int cycle_count = 0;

   bit send_idle_en = 1'b1;
   bit rsp_idle_en = 1'b1;
   int hold_seq = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stall_left = 0;

   task automatic apply_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                                input logic [TAG_W-1:0] tag, input logic [DUR_W-1:0] dur,
                                input logic [TICK_W-1:0] tv);
      logic [63:0] product;
      expiry_word_type word;
      int hits;
      hits = 0;
      case (op)
         OP_TICK: begin
            bank_now = tv;
            for (int i = 0; i < SLOTS; i++) begin
               if (timer_armed[i] && (tv - timer_start[i]) >= timer_limit[i]) begin
                  timer_armed[i] = 1'b0;
                  word.slot = SLOT_W'(i);
                  word.tag = timer_tag[i];
                  word.last = 1'b0;
                  expiry_q.push_back(word);
                  hits++;
               end
            end
            if (hits > 0)
               expiry_q[expiry_q.size() - 1].last = 1'b1;
         end
         OP_REBASE: begin
            bank_now = tv;
            for (int i = 0; i < SLOTS; i++)
               if (timer_armed[i])
                  timer_start[i] = tv;
         end
         OP_START: begin
            if (int'(slot) < SLOTS && dur != '0) begin
               product = {32'b0, dur} * {48'b0, bank_tpm};
               timer_limit[slot] = product[TICK_W-1:0];
               timer_start[slot] = bank_now;
               timer_tag[slot] = tag;
               timer_armed[slot] = 1'b1;
            end
         end
         OP_STOP: begin
            if (int'(slot) < SLOTS)
               timer_armed[slot] = 1'b0;
         end
         OP_RELEASE: begin
            if (int'(slot) < SLOTS) begin
               timer_armed[slot] = 1'b0;
               timer_start[slot] = '0;
               timer_limit[slot] = '0;
               timer_tag[slot] = '0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic offer_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                                input logic [TAG_W-1:0] tag, input logic [DUR_W-1:0] dur,
                                input logic [TICK_W-1:0] tv);
      int gap;
      if (send_idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.operation   <= op;
      req_if.slot        <= slot;
      req_if.tag         <= tag;
      req_if.duration_ms <= dur;
      req_if.tick_value  <= tv;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      apply_request(op, slot, tag, dur, tv);
   endtask

   // wait until the bank has reported everything and gone quiet
   task automatic settle_bank();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expiry_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ticks_per_ms(input logic [TPM_W-1:0] value);
      settle_bank();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      bank_tpm = value;
   endtask

   task automatic test_idle_ticks();
      offer_request(OP_TICK, '0, '0, '0, '0);
      offer_request(OP_TICK, '1, '1, '1, '1);
   endtask

   task automatic test_start_and_expire();
      write_ticks_per_ms(TPM_RESET);
      offer_request(OP_REBASE, '0, '0, '0, 32'hFFFF_FFF0);
      offer_request(OP_START, 3'd0, 8'h00, 32'h20, '0);
      offer_request(OP_START, 3'd7, 8'hFF, 32'hFFFF_FFFF, '0);
      // zero duration leaves the slot alone
      offer_request(OP_START, 3'd3, 8'hA5, '0, '1);
      offer_request(OP_TICK, '0, '0, '0, 32'h0000_000F);
      offer_request(OP_TICK, '0, '0, '0, 32'h0000_0010);
      offer_request(OP_TICK, '0, '0, '0, 32'hFFFF_FFEF);
   endtask

   task automatic test_stop_and_release();
      offer_request(OP_START, 3'd2, 8'h5A, 32'd5, '0);
      offer_request(OP_STOP, 3'd2, '1, '1, '1);
      offer_request(OP_START, 3'd4, 8'h3C, 32'd1, '0);
      offer_request(OP_RELEASE, 3'd4, '0, '0, '0);
      offer_request(OP_RELEASE, 3'd1, '0, '0, '0);
      offer_request(OP_TICK, '0, '0, '0, bank_now + 32'd1000);
   endtask

   task automatic test_rebase();
      offer_request(OP_START, 3'd1, 8'h11, 32'd10, '0);
      offer_request(OP_START, 3'd6, 8'h66, 32'd10, '0);
      offer_request(OP_REBASE, '0, '0, '0, bank_now + 32'd100);
      offer_request(OP_TICK, '0, '0, '0, bank_now + 32'd9);
      offer_request(OP_TICK, '0, '0, '0, bank_now + 32'd1);
   endtask

   task automatic test_scale_extremes();
      // scaled limit wraps to zero and fires on the next tick
      write_ticks_per_ms(TPM_HALF);
      offer_request(OP_START, 3'd5, 8'h77, 32'h0002_0000, '0);
      offer_request(OP_TICK, '0, '0, '0, bank_now);
      write_ticks_per_ms(TPM_MAX);
      offer_request(OP_START, 3'd0, 8'h81, 32'hFFFF_FFFF, '0);
      offer_request(OP_TICK, '0, '0, '0, bank_now + 32'hFFFF_0000);
      offer_request(OP_TICK, '0, '0, '0, bank_now + 32'd1);
   endtask

   task automatic test_unused_ops();
      for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
         offer_request(OP_W'(op), '1, '1, '1, '1);
   endtask

   task automatic send_random_request();
      int pick;
      logic [SLOT_W-1:0] slot;
      logic [TAG_W-1:0]  tag;
      logic [DUR_W-1:0]  dur;
      logic [TICK_W-1:0] tv;
      pick = $urandom_range(0, 99);
      slot = SLOT_W'($urandom);
      tag  = TAG_W'($urandom);
      dur  = $urandom;
      tv   = $urandom;
      if (pick < 40) begin
         case ($urandom_range(0, 19))
            0: dur = '0;
            1: dur = $urandom;
            default: dur = DUR_W'($urandom_range(1, 20));
         endcase
         offer_request(OP_START, slot, tag, dur, tv);
      end else if (pick < 70) begin
         if ($urandom_range(0, 19) != 0)
            tv = bank_now + TICK_W'($urandom_range(0, 30)) * TICK_W'(bank_tpm);
         offer_request(OP_TICK, slot, tag, dur, tv);
      end else if (pick < 78) begin
         offer_request(OP_STOP, slot, tag, dur, tv);
      end else if (pick < 84) begin
         offer_request(OP_RELEASE, slot, tag, dur, tv);
      end else if (pick < 90) begin
         if ($urandom_range(0, 3) != 0)
            tv = bank_now + TICK_W'($urandom_range(0, 10)) * TICK_W'(bank_tpm);
         offer_request(OP_REBASE, slot, tag, dur, tv);
      end else begin
         offer_request(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), slot, tag, dur, tv);
      end
   endtask

   task automatic test_random_phase(input int count, input logic [TPM_W-1:0] tpm,
                                    input bit idle_on);
      write_ticks_per_ms(tpm);
      send_idle_en = idle_on;
      rsp_idle_en = idle_on;
      repeat (count) send_random_request();
   endtask

   // hold the response side off so the bank fills up and stalls its input
   task automatic test_backpressure();
      write_ticks_per_ms(TPM_RESET);
      send_idle_en = 1'b0;
      for (int i = 0; i < SLOTS; i++)
         offer_request(OP_START, SLOT_W'(i), TAG_W'($urandom), DUR_W'(i + 1), '0);
      hold_seq++;
      offer_request(OP_TICK, '0, '0, '0, bank_now + 32'd100);
      for (int i = 0; i < 3; i++)
         offer_request(OP_START, SLOT_W'(i), TAG_W'($urandom), DUR_W'(2), '0);
      offer_request(OP_TICK, '0, '0, '0, bank_now + 32'd5);
      offer_request(OP_STOP, 3'd1, '0, '0, '0);
      offer_request(OP_TICK, '0, '0, '0, bank_now + 32'd5);
   endtask

   // response ready with random stalls and the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_left = PRESSURE_HOLD - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (rsp_idle_en && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      expiry_word_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expiry_q.size() == 0) begin
            if (mismatches < REPORT_MAX)
               $display("unexpected expiry word: slot %0d tag %02h last %0b",
                        rsp_if.expired_slot, rsp_if.expired_tag, rsp_if.last);
            mismatches++;
         end else begin
            want = expiry_q.pop_front();
            if (rsp_if.expired_slot !== want.slot || rsp_if.expired_tag !== want.tag ||
                rsp_if.last !== want.last) begin
               if (mismatches < REPORT_MAX) begin
                  $display("expiry mismatch: expected slot %0d tag %02h last %0b",
                           want.slot, want.tag, want.last);
                  $display("                 got slot %0d tag %02h last %0b",
                           rsp_if.expired_slot, rsp_if.expired_tag, rsp_if.last);
               end
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("one_shot_timer_bank verification failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         timer_armed[i] = 1'b0;
         timer_start[i] = '0;
         timer_limit[i] = '0;
         timer_tag[i] = '0;
      end
      bank_now = '0;
      bank_tpm = TPM_RESET;
      req_if.valid       <= 1'b0;
      req_if.operation   <= '0;
      req_if.slot        <= '0;
      req_if.tag         <= '0;
      req_if.duration_ms <= '0;
      req_if.tick_value  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_ticks();
      test_start_and_expire();
      test_stop_and_release();
      test_rebase();
      test_scale_extremes();
      test_unused_ops();
      test_random_phase(60, TPM_RESET, 1'b1);
      test_random_phase(60, TPM_W'($urandom_range(2, 9)), 1'b1);
      test_random_phase(50, TPM_MAX, 1'b1);
      test_backpressure();
      test_random_phase(60, TPM_W'($urandom_range(2, 5)), 1'b0);

      settle_bank();
      if (mismatches == 0 && expiry_q.size() == 0) begin
         $display("one_shot_timer_bank verification clean");
      end else begin
         $display("one_shot_timer_bank verification failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/otb_pkg.sv
rtl/otb_ifs.sv
rtl/otb_ctrl.sv
rtl/otb_dp.sv
rtl/one_shot_timer_bank.sv
verif/one_shot_timer_bank_tb.sv
